@@ design/cordic_cartesian_to_polar_top_defines.svh @@
// Assertion macros shared by the cartesian-to-polar CORDIC modules.
`ifndef CORDIC_CARTESIAN_TO_POLAR_TOP_DEFINES_SVH
`define CORDIC_CARTESIAN_TO_POLAR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CC2P_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cc2p: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CC2P_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("cc2p: next-cycle check failed");

`endif

@@ design/cc2p_pkg.sv @@
// Package: payload types, fixed-point formats and CORDIC table constants.
`timescale 1ns / 1ps
package cc2p_pkg;

    localparam int FIELD_W   = 16;
    localparam int R_FRAC    = 16;
    localparam int ANG_FRAC  = 60;
    localparam int GAIN_FRAC = 24;
    localparam int GAIN_W    = 24;
    localparam int ACC_W     = 64;
    localparam int XL_W      = 18;

    typedef struct packed {
        logic signed [FIELD_W-1:0] x_coord;
        logic signed [FIELD_W-1:0] y_coord;
    } in_t;

    typedef struct packed {
        logic        [FIELD_W-1:0] magnitude;
        logic signed [FIELD_W-1:0] phase;
    } out_t;

    // Restoring division, used only to build constants at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/m) with ANG_FRAC fractional bits, by the alternating series.
    function automatic logic [63:0] atan_recip(input logic [63:0] m);
        logic [63:0] m2;
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] sum;
        logic [63:0] part;
        logic        neg;
        m2   = m * m;
        term = udiv64(64'd1 << ANG_FRAC, m);
        k    = 64'd1;
        sum  = '0;
        neg  = 1'b0;
        while (term != 64'd0) begin
            part = udiv64(term, k);
            sum  = neg ? (sum - part) : (sum + part);
            neg  = !neg;
            term = udiv64(term, m2);
            k    = k + 64'd2;
        end
        return sum;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = '0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 64'd0) begin
            if (v >= res + bit_w) begin
                v   = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [ACC_W-1:0] atan_pow2(input int i);
        return signed'(atan_recip(64'd1 << i));
    endfunction

    function automatic logic [63:0] calc_pi();
        return 64'd16 * atan_recip(64'd5) - 64'd4 * atan_recip(64'd239);
    endfunction

    // Reciprocal of the CORDIC gain after n micro-rotations.
    function automatic logic [GAIN_W-1:0] gain_comp(input int n);
        logic [63:0] prod;
        logic [63:0] root;
        prod = 64'd1 << ANG_FRAC;
        for (int i = 1; i <= n; i++) begin
            prod = prod + (prod >> (2 * i));
        end
        root = isqrt64(prod);
        return GAIN_W'(udiv64(64'd1 << (30 + GAIN_FRAC), root));
    endfunction

    localparam logic signed [ACC_W-1:0] PI_FIX      = signed'(calc_pi());
    localparam logic signed [ACC_W-1:0] HALF_PI_FIX = PI_FIX >>> 1;
    localparam logic signed [ACC_W-1:0] TWO_PI_FIX  = PI_FIX <<< 1;

endpackage

@@ design/cc2p_coarse.sv @@
// Coarse rotation cell: sign-extends the sample and turns it into the sector |y| <= x.
`timescale 1ns / 1ps
`include "cordic_cartesian_to_polar_top_defines.svh"
module cc2p_coarse import cc2p_pkg::*; #(
    parameter int SAMPLE_BITS = 16,
    parameter int XW          = 35
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  in_t                     in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [XW-1:0]    out_x,
    output logic signed [XW-1:0]    out_y,
    output logic signed [ACC_W-1:0] out_phi
);

    localparam int RAW_W = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;

    logic [RAW_W-1:0]              raw_x;
    logic [RAW_W-1:0]              raw_y;
    logic signed [SAMPLE_BITS-1:0] smp_x;
    logic signed [SAMPLE_BITS-1:0] smp_y;
    logic signed [XW-1:0]          xi;
    logic signed [XW-1:0]          yi;
    logic signed [XW-1:0]          diff;
    logic signed [XW-1:0]          total;
    logic signed [XW-1:0]          xsel;
    logic signed [XW-1:0]          ysel;
    logic signed [XW-1:0]          x_next;
    logic signed [XW-1:0]          y_next;
    logic signed [ACC_W-1:0]       phi_next;
    logic signed [XW-1:0]          x_reg;
    logic signed [XW-1:0]          y_reg;
    logic signed [ACC_W-1:0]       phi_reg;
    logic                          valid_reg;
    logic                          advance;

    assign raw_x = RAW_W'($unsigned(in_data.x_coord));
    assign raw_y = RAW_W'($unsigned(in_data.y_coord));
    assign smp_x = signed'(raw_x[SAMPLE_BITS-1:0]);
    assign smp_y = signed'(raw_y[SAMPLE_BITS-1:0]);
    assign xi    = XW'(smp_x);
    assign yi    = XW'(smp_y);
    assign diff  = xi - yi;
    assign total = xi + yi;

    always_comb begin
        if (!diff[XW-1]) begin
            if (!total[XW-1]) begin
                xsel = xi;  ysel = yi;  phi_next = '0;
            end else begin
                xsel = -yi; ysel = xi;  phi_next = HALF_PI_FIX;
            end
        end else begin
            if (!total[XW-1]) begin
                xsel = yi;  ysel = -xi; phi_next = -HALF_PI_FIX;
            end else begin
                xsel = -xi; ysel = -yi; phi_next = PI_FIX;
            end
        end
        x_next = xsel <<< R_FRAC;
        y_next = ysel <<< R_FRAC;
    end

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            phi_reg <= phi_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_phi   = phi_reg;

    `CC2P_ASSERT_IMPLY(a_sector, aclk, aresetn, valid_reg, (x_reg >= y_reg) && (x_reg >= -y_reg))

endmodule

@@ design/cc2p_cell.sv @@
// Micro-rotation cell: one shift-add CORDIC step and one angle table add.
`timescale 1ns / 1ps
`include "cordic_cartesian_to_polar_top_defines.svh"
module cc2p_cell import cc2p_pkg::*; #(
    parameter int                      XW    = 35,
    parameter int                      SHIFT = 1,
    parameter logic signed [ACC_W-1:0] ANGLE = 64'sd0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [XW-1:0]    in_x,
    input  logic signed [XW-1:0]    in_y,
    input  logic signed [ACC_W-1:0] in_phi,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [XW-1:0]    out_x,
    output logic signed [XW-1:0]    out_y,
    output logic signed [ACC_W-1:0] out_phi
);

    logic signed [XW-1:0]    xs;
    logic signed [XW-1:0]    ys;
    logic signed [XW-1:0]    x_next;
    logic signed [XW-1:0]    y_next;
    logic signed [ACC_W-1:0] phi_next;
    logic signed [XW-1:0]    x_reg;
    logic signed [XW-1:0]    y_reg;
    logic signed [ACC_W-1:0] phi_reg;
    logic                    valid_reg;
    logic                    advance;

    assign xs = in_x >>> SHIFT;
    assign ys = in_y >>> SHIFT;

    // Rotate toward y = 0; zero counts as non-negative.
    always_comb begin
        if (!in_y[XW-1]) begin
            x_next   = in_x + ys;
            y_next   = in_y - xs;
            phi_next = in_phi - ANGLE;
        end else begin
            x_next   = in_x - ys;
            y_next   = in_y + xs;
            phi_next = in_phi + ANGLE;
        end
    end

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            phi_reg <= phi_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_phi   = phi_reg;

    `CC2P_ASSERT_IMPLY(a_x_nonneg, aclk, aresetn, valid_reg, !x_reg[XW-1])

endmodule

@@ design/cc2p_post.sv @@
// Output stages: gain compensation by split multiply, phase fold and output register.
`timescale 1ns / 1ps
module cc2p_post import cc2p_pkg::*; #(
    parameter int XW              = 35,
    parameter int ITERATIONS      = 16,
    parameter int PHASE_FRAC_BITS = 13
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [XW-1:0]    in_x,
    input  logic signed [ACC_W-1:0] in_phi,
    output logic                    out_valid,
    input  logic                    out_ready,
    output out_t                    out_data
);

    localparam logic [GAIN_W-1:0] GAIN_FIX = gain_comp(ITERATIONS);
    localparam int XH_W        = XW - 1 - XL_W;
    localparam int PL_W        = XL_W + GAIN_W;
    localparam int PH_W        = XH_W + GAIN_W;
    localparam int PHASE_SHIFT = ANG_FRAC - PHASE_FRAC_BITS;
    localparam int MAG_SHIFT   = R_FRAC + GAIN_FRAC;

    logic [XW-2:0]           xpos;
    logic [XL_W-1:0]         xl;
    logic [XH_W-1:0]         xh;
    logic [PL_W-1:0]         pl_next;
    logic [PH_W-1:0]         ph_next;
    logic signed [ACC_W-1:0] res_full;
    logic signed [ACC_W-1:0] res_sh;
    logic [PL_W-1:0]         pl_reg;
    logic [PH_W-1:0]         ph_reg;
    logic [FIELD_W-1:0]      phase1_reg;
    logic                    v1_reg;
    logic [63:0]             prod_sum;
    logic [63-MAG_SHIFT:0]   mag_q;
    logic [FIELD_W-1:0]      mag_next;
    logic [FIELD_W-1:0]      mag_reg;
    logic [FIELD_W-1:0]      phase2_reg;
    logic                    v2_reg;
    logic                    adv1;
    logic                    adv2;

    // Clamp negative x to zero, then split it for two narrow products.
    assign xpos    = in_x[XW-1] ? '0 : in_x[XW-2:0];
    assign xl      = xpos[XL_W-1:0];
    assign xh      = xpos[XW-2:XL_W];
    assign pl_next = PL_W'(xl) * PL_W'(GAIN_FIX);
    assign ph_next = PH_W'(xh) * PH_W'(GAIN_FIX);

    // Fold the negated accumulator into [-pi, pi), then floor to the output scale.
    assign res_full = (in_phi > PI_FIX) ? (TWO_PI_FIX - in_phi) : -in_phi;
    assign res_sh   = res_full >>> PHASE_SHIFT;

    assign prod_sum = (64'(ph_reg) << XL_W) + 64'(pl_reg);
    assign mag_q    = prod_sum[63:MAG_SHIFT];
    assign mag_next = (|mag_q[63-MAG_SHIFT:FIELD_W]) ? '1 : mag_q[FIELD_W-1:0];

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            pl_reg     <= pl_next;
            ph_reg     <= ph_next;
            phase1_reg <= res_sh[FIELD_W-1:0];
        end
        if (adv2 && v1_reg) begin
            mag_reg    <= mag_next;
            phase2_reg <= phase1_reg;
        end
    end

    assign out_valid          = v2_reg;
    assign out_data.magnitude = mag_reg;
    assign out_data.phase     = signed'(phase2_reg);

endmodule

@@ design/cordic_cartesian_to_polar_top.sv @@
// Top level: cartesian-to-polar converter built as a chain of CORDIC cells.
`timescale 1ns / 1ps
`include "cordic_cartesian_to_polar_top_defines.svh"
// Converts one signed (x, y) sample per transfer into magnitude and phase by
// vectoring-mode CORDIC. A coarse cell first rotates the vector by 0, +pi/2,
// -pi/2 or pi into the sector |y| <= x; ITERATIONS micro-rotation cells follow,
// one per shift amount, each a registered stage; two output stages apply the
// gain compensation (split into two narrow multiplies, then summed) and fold the
// phase into [-pi, pi). Magnitude is an unsigned integer saturating at 65535;
// phase is radians with PHASE_FRAC_BITS fractional bits, wrapped to 16 bits.
// Throughput is one transfer per cycle while m_ready stays high; its stages are
// one coarse cell, one cell per iteration and two output stages, set by the
// length of the cell chain. Every stage holds its own valid bit and accepts new
// data whenever it is empty or its successor advances, so bubbles are squeezed
// out and the input takes transfers while a result waits, until all stages fill.
// Zero input gives magnitude 0 and the phase of a plain CORDIC run on y = 0.
module cordic_cartesian_to_polar_top import cc2p_pkg::*; #(
    parameter int SAMPLE_BITS     = 16,
    parameter int ITERATIONS      = 16,
    parameter int PHASE_FRAC_BITS = 13
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    // Datapath width: sample, fraction bits, CORDIC growth and sign headroom.
    localparam int XW = SAMPLE_BITS + R_FRAC + 3;

    logic                    c_valid [0:ITERATIONS];
    logic                    c_ready [0:ITERATIONS];
    logic signed [XW-1:0]    c_x     [0:ITERATIONS];
    logic signed [XW-1:0]    c_y     [0:ITERATIONS];
    logic signed [ACC_W-1:0] c_phi   [0:ITERATIONS];

    // Coarse sector rotation.
    cc2p_coarse #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .XW         (XW)
    ) u_coarse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (s_data),
        .out_valid(c_valid[0]),
        .out_ready(c_ready[0]),
        .out_x    (c_x[0]),
        .out_y    (c_y[0]),
        .out_phi  (c_phi[0])
    );

    // One cell per micro-rotation; cell g shifts by g and steps by atan(2^-g).
    for (genvar g = 1; g <= ITERATIONS; g++) begin : g_cell
        cc2p_cell #(
            .XW   (XW),
            .SHIFT(g),
            .ANGLE(atan_pow2(g))
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_valid (c_valid[g-1]),
            .in_ready (c_ready[g-1]),
            .in_x     (c_x[g-1]),
            .in_y     (c_y[g-1]),
            .in_phi   (c_phi[g-1]),
            .out_valid(c_valid[g]),
            .out_ready(c_ready[g]),
            .out_x    (c_x[g]),
            .out_y    (c_y[g]),
            .out_phi  (c_phi[g])
        );
    end

    // Gain compensation, phase fold and the output register.
    cc2p_post #(
        .XW             (XW),
        .ITERATIONS     (ITERATIONS),
        .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
    ) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (c_valid[ITERATIONS]),
        .in_ready (c_ready[ITERATIONS]),
        .in_x     (c_x[ITERATIONS]),
        .in_phi   (c_phi[ITERATIONS]),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (m_data)
    );

    // With the output register empty every stage can advance.
    `CC2P_ASSERT_IMPLY(a_empty_ready, aclk, aresetn, !m_valid, s_ready)
    // An accepted transfer lands in the coarse cell on the next edge.
    `CC2P_ASSERT_NEXT(a_enter, aclk, aresetn, s_valid && s_ready, c_valid[0])

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the cartesian-to-polar CORDIC converter.
`timescale 1ns / 1ps
module tb;
    import cc2p_pkg::*;

    // Watchdog: cycles in a row with work outstanding but no transfer on either side.
    localparam int STALL_LIMIT   = 5000;
    // Settle time after the last result, well beyond the ITERATIONS + 3 stages.
    localparam int TAIL_CYCLES   = 40;
    localparam int RANDOM_ITEMS  = 650;
    localparam int NUM_ITER      = 16;
    localparam int OUT_FRAC      = 13;
    localparam int SAMPLE_FRAC   = 16;
    localparam int ANGLE_FRAC    = 60;
    localparam int GAIN_SHIFT    = 24;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    cordic_cartesian_to_polar_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns period: 6 ns low, 6 ns high.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Samples waiting to be driven, and polar results still owed by the block.
    in_t  sample_q[$];
    out_t polar_expect_q[$];

    // Idle percentages per side; changed only while the block is drained.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    // Hold the sender off, so the pipeline empties with input still queued.
    logic hold_tx       = 1'b0;

    int   mismatch_cnt  = 0;
    int   stall_cnt     = 0;

    // Our own copy of the CORDIC constants, built at time zero.
    longint          atan_lut [1:NUM_ITER];
    longint          pi_val;
    longint unsigned gain_val;

    // atan(1/m) at ANGLE_FRAC fractional bits by the alternating series.
    function automatic longint arctan_inv(longint unsigned m);
        longint unsigned m2;
        longint unsigned term;
        longint unsigned k;
        longint          sum;
        bit              neg;
        m2   = m * m;
        term = (64'd1 << ANGLE_FRAC) / m;
        k    = 1;
        sum  = 0;
        neg  = 1'b0;
        while (term != 0) begin
            if (neg) sum = sum - longint'(term / k);
            else     sum = sum + longint'(term / k);
            neg  = !neg;
            term = term / m2;
            k    = k + 2;
        end
        return sum;
    endfunction

    // Vectoring-mode CORDIC on one sample: magnitude and folded phase.
    function automatic out_t predict_polar(in_t smp);
        longint          xi;
        longint          yi;
        longint          xv;
        longint          yv;
        longint          ph;
        longint          xs;
        longint          ys;
        longint          rv;
        longint unsigned magv;
        out_t            r;
        xi = longint'($signed(smp.x_coord));
        yi = longint'($signed(smp.y_coord));
        // Coarse turn into the sector |y| <= x; ties count as non-negative.
        if (xi - yi >= 0) begin
            if (xi + yi >= 0) begin
                xv = xi;  yv = yi;  ph = 0;
            end else begin
                xv = -yi; yv = xi;  ph = pi_val >>> 1;
            end
        end else begin
            if (xi + yi >= 0) begin
                xv = yi;  yv = -xi; ph = -(pi_val >>> 1);
            end else begin
                xv = -xi; yv = -yi; ph = pi_val;
            end
        end
        xv = xv <<< SAMPLE_FRAC;
        yv = yv <<< SAMPLE_FRAC;
        for (int i = 1; i <= NUM_ITER; i++) begin
            ys = yv >>> i;
            xs = xv >>> i;
            if (yv >= 0) begin
                xv = xv + ys;
                yv = yv - xs;
                ph = ph - atan_lut[i];
            end else begin
                xv = xv - ys;
                yv = yv + xs;
                ph = ph + atan_lut[i];
            end
        end
        if (xv < 0) xv = 0;
        magv = ($unsigned(xv) * gain_val) >> (SAMPLE_FRAC + GAIN_SHIFT);
        if (magv > 64'hFFFF) magv = 64'hFFFF;
        // Fold the negated accumulator into [-pi, pi), then floor to the output scale.
        rv = (ph > pi_val) ? (2 * pi_val - ph) : -ph;
        rv = rv >>> (ANGLE_FRAC - OUT_FRAC);
        r.magnitude = magv[15:0];
        r.phase     = rv[15:0];
        return r;
    endfunction

    function automatic in_t make_sample(int sx, int sy);
        in_t t;
        t.x_coord = sx[15:0];
        t.y_coord = sy[15:0];
        return t;
    endfunction

    // Random sample: mostly full range, with weight on ties, axes and tiny vectors.
    function automatic in_t rand_sample();
        int sel;
        int a;
        int b;
        sel = $urandom_range(99);
        a   = $urandom_range(65535) - 32768;
        b   = $urandom_range(65535) - 32768;
        if (sel < 50) begin
            return make_sample(a, b);
        end else if (sel < 65) begin
            return make_sample($urandom_range(16) - 8, $urandom_range(16) - 8);
        end else if (sel < 80) begin
            // x = y or x = -y, the sector boundaries
            if (a == -32768) a = -32767;
            return make_sample(a, ($urandom_range(1) != 0) ? a : -a);
        end else if (sel < 90) begin
            // on or next to an axis, extremes included
            a = ($urandom_range(1) != 0) ? 32767 : -32768;
            b = $urandom_range(2) - 1;
            return ($urandom_range(1) != 0) ? make_sample(a, b) : make_sample(b, a);
        end else begin
            return make_sample(a, $urandom_range(6) - 3);
        end
    endfunction

    task automatic queue_random(int n);
        for (int k = 0; k < n; k++) begin
            sample_q.push_back(rand_sample());
        end
    endtask

    // Block until every queued sample is sent (unless held off) and every result is in.
    task automatic wait_drained();
        while (s_valid || polar_expect_q.size() != 0 || (!hold_tx && sample_q.size() != 0)) begin
            @(negedge aclk);
        end
    endtask

    // Driver: record the expectation on each input transfer, then offer the next
    // sample or drop valid. Valid is held with a fixed payload until it transfers.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                polar_expect_q.push_back(predict_polar(s_data));
            end
            if (!s_valid || s_ready) begin
                if (sample_q.size() != 0 && !hold_tx &&
                    $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data  <= sample_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall the result side at random and check each result transfer
    // against the oldest expectation, field by field.
    always @(posedge aclk) begin
        out_t want;
        m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (polar_expect_q.size() == 0) begin
                if (mismatch_cnt < 10) begin
                    $display("[%0t] unexpected result: magnitude %0d phase %0d",
                             $realtime, m_data.magnitude, $signed(m_data.phase));
                end
                mismatch_cnt <= mismatch_cnt + 1;
            end else begin
                want = polar_expect_q.pop_front();
                if (m_data.magnitude !== want.magnitude || m_data.phase !== want.phase) begin
                    if (mismatch_cnt < 10) begin
                        $display("[%0t] mismatch: magnitude exp %0d got %0d, phase exp %0d got %0d",
                                 $realtime, want.magnitude, m_data.magnitude,
                                 $signed(want.phase), $signed(m_data.phase));
                    end
                    mismatch_cnt <= mismatch_cnt + 1;
                end
            end
        end
    end

    // Watchdog: end the run if work is outstanding and nothing transfers for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cnt <= 0;
            end else if (s_valid || sample_q.size() != 0 || polar_expect_q.size() != 0) begin
                stall_cnt <= stall_cnt + 1;
                if (stall_cnt + 1 >= STALL_LIMIT) begin
                    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
                    $display("FAIL cordic_cartesian_to_polar_top");
                    $finish;
                end
            end
        end
    end

    initial begin
        longint unsigned prod;
        longint unsigned sq_v;
        longint unsigned sq_res;
        longint unsigned sq_bit;

        // Build the angle table, pi and the gain compensation constant.
        prod = 64'd1 << ANGLE_FRAC;
        for (int i = 1; i <= NUM_ITER; i++) begin
            atan_lut[i] = arctan_inv(64'd1 << i);
            prod        = prod + (prod >> (2 * i));
        end
        pi_val = 16 * arctan_inv(5) - 4 * arctan_inv(239);
        sq_v   = prod;
        sq_res = 0;
        sq_bit = 64'd1 << 62;
        while (sq_bit > sq_v) sq_bit = sq_bit >> 2;
        while (sq_bit != 0) begin
            if (sq_v >= sq_res + sq_bit) begin
                sq_v   = sq_v - (sq_res + sq_bit);
                sq_res = (sq_res >> 1) + sq_bit;
            end else begin
                sq_res = sq_res >> 1;
            end
            sq_bit = sq_bit >> 2;
        end
        gain_val = (64'd1 << (30 + GAIN_SHIFT)) / sq_res;

        // Hold reset once, then release it.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Phase 1: sender idles 35%, receiver 67%.
        send_idle_pct = 35;
        recv_idle_pct = 67;

        // Directed: zero vector, axis and diagonal extremes, sector ties, unit steps.
        sample_q.push_back(make_sample(0, 0));
        sample_q.push_back(make_sample(32767, 0));
        sample_q.push_back(make_sample(-32768, 0));
        sample_q.push_back(make_sample(0, 32767));
        sample_q.push_back(make_sample(0, -32768));
        sample_q.push_back(make_sample(32767, 32767));
        sample_q.push_back(make_sample(-32768, -32768));
        sample_q.push_back(make_sample(32767, -32768));
        sample_q.push_back(make_sample(-32768, 32767));
        sample_q.push_back(make_sample(100, 100));
        sample_q.push_back(make_sample(100, -100));
        sample_q.push_back(make_sample(-100, 100));
        sample_q.push_back(make_sample(-100, -100));
        sample_q.push_back(make_sample(1, 0));
        sample_q.push_back(make_sample(0, 1));
        sample_q.push_back(make_sample(-1, 0));
        sample_q.push_back(make_sample(0, -1));
        sample_q.push_back(make_sample(1, 1));
        sample_q.push_back(make_sample(-1, -1));
        sample_q.push_back(make_sample(1, -1));
        sample_q.push_back(make_sample(-1, 1));
        sample_q.push_back(make_sample(-32768, -32767));
        sample_q.push_back(make_sample(12345, -321));
        queue_random(RANDOM_ITEMS / 3);
        wait_drained();

        // Phase 2: roles swapped; halfway, hold the sender until the pipe is empty.
        send_idle_pct = 67;
        recv_idle_pct = 35;
        queue_random(RANDOM_ITEMS / 3);
        while (sample_q.size() > RANDOM_ITEMS / 6) @(negedge aclk);
        hold_tx = 1'b1;
        wait_drained();
        hold_tx = 1'b0;
        wait_drained();

        // Phase 3: no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        wait_drained();

        // Let any stray result surface before the verdict.
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatch_cnt == 0 && polar_expect_q.size() == 0) begin
            $display("PASS cordic_cartesian_to_polar_top");
        end else begin
            $display("FAIL cordic_cartesian_to_polar_top");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/cc2p_pkg.sv
design/cc2p_coarse.sv
design/cc2p_cell.sv
design/cc2p_post.sv
design/cordic_cartesian_to_polar_top.sv
test/tb.sv
